// ----- src/pps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; every other file imports this package.
package pps_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int TIME_W        = 21;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Request function codes
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_ADDED = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RAN   = 2'd2;
   localparam logic [1:0] STATUS_IDLE  = 2'd3;

   typedef struct packed {
      logic        func;
      logic [7:0]  proc_id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        run_id;
      logic              finished;
      logic [TIME_W-1:0] completion;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] wait_time;
   } rsp_type;

   // One slot of the process table as held in memory
   typedef struct packed {
      logic [7:0]  proc_id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  prio;
      logic [15:0] remaining;
   } slot_type;

   // Control from the sequencer to the best-candidate tracker
   typedef struct packed {
      logic clear;
      logic sample;
      logic slot_valid;
   } trk_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

// ----- src/pps_slot_mem.sv -----
`timescale 1ns / 1ps
// Process table memory: one write port, one read port, registered read data.
// Depends on pps_pkg for the slot entry type.
module pps_slot_mem #(
   parameter int SLOTS = pps_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(SLOTS)-1:0]   wr_addr,
   input  pps_pkg::slot_type          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(SLOTS)-1:0]   rd_addr,
   output pps_pkg::slot_type          rd_data
);
   import pps_pkg::*;

   slot_type mem [SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/pps_best_track.sv -----
`timescale 1ns / 1ps
// Keeps the best ready candidate seen so far during a table scan.
// Depends on pps_pkg for the slot and control types.
module pps_best_track #(
   parameter int SLOTS = pps_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pps_pkg::trk_ctl_type              ctl,
   input  logic [$clog2(SLOTS)-1:0]          slot_idx,
   input  pps_pkg::slot_type                 entry,
   input  logic [pps_pkg::TIME_W-1:0]        now,
   output logic                              found,
   output logic [$clog2(SLOTS)-1:0]          best_slot,
   output pps_pkg::slot_type                 best_entry
);
   import pps_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   logic             found_ff, found_in;
   logic [IDX_W-1:0] slot_ff,  slot_in;
   slot_type         entry_ff, entry_in;
   logic             ready;
   logic             better;

   // Strict compares keep the lower slot on a full tie, since slots arrive in order
   always_comb begin
      ready  = ctl.sample && ctl.slot_valid && ({5'd0, entry.arrival} <= now);
      better = !found_ff || (entry.prio > entry_ff.prio) ||
               ((entry.prio == entry_ff.prio) && (entry.arrival < entry_ff.arrival));
      found_in = found_ff;
      slot_in  = slot_ff;
      entry_in = entry_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ready && better) begin
         found_in = 1'b1;
         slot_in  = slot_idx;
         entry_in = entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      entry_ff <= entry_in;
   end

   assign found      = found_ff;
   assign best_slot  = slot_ff;
   assign best_entry = entry_ff;

endmodule

// ----- src/preemptive_priority_scheduler.sv -----
`timescale 1ns / 1ps
// Preemptive priority scheduler, top level. Depends on pps_pkg, pps_slot_mem, pps_best_track.
// Add beat: free slots are found by a walk over the valid bits, one slot a cycle.
// Tick beat: the table memory is read one slot a cycle through its single read port,
//   then the chosen slot is written back.
// One beat in flight; a new request is taken once the result sits in the output register.
// Reset (synchronous): all slots free, time zero, no result pending. Memory is not cleared.
module preemptive_priority_scheduler #(
   parameter int SLOTS = pps_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pps_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pps_pkg::rsp_type  rsp_payload
);
   import pps_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Sequencer state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   req_type          req_ff;
   logic             samp_ff, samp_in;
   logic [IDX_W-1:0] samp_idx_ff;

   // Architectural state held in flops
   logic [SLOTS-1:0]  valid_ff;
   logic [TIME_W-1:0] now_ff, now_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_load;

   // Memory ports
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   slot_type         mem_wdata;
   logic             mem_re;
   slot_type         mem_rdata;

   // Tracker
   trk_ctl_type      trk_ctl;
   logic             best_found;
   logic [IDX_W-1:0] best_slot;
   slot_type         best_entry;

   // Valid bit updates
   logic             valid_set, valid_clr;
   logic [IDX_W-1:0] valid_idx;

   logic              req_accept;
   logic              out_free;
   logic              slot_free;
   logic              is_last;
   logic [TIME_W-1:0] comp;
   logic [TIME_W-1:0] tat;
   logic [TIME_W-1:0] bur;
   logic [TIME_W-1:0] wt;
   logic              done;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign slot_free  = !valid_ff[idx_ff];
   assign is_last    = (idx_ff == LAST_IDX);

   // Finish-time arithmetic; arrival never exceeds now, so turnaround cannot wrap
   always_comb begin
      comp = (now_ff == TIME_MAX) ? TIME_MAX : now_ff + TIME_W'(1);
      tat  = comp - {5'd0, best_entry.arrival};
      bur  = {5'd0, best_entry.burst};
      wt   = (tat >= bur) ? tat - bur : '0;
      done = (best_entry.remaining <= 16'd1);
   end

   pps_slot_mem #(.SLOTS(SLOTS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (idx_ff),
      .rd_data (mem_rdata)
   );

   pps_best_track #(.SLOTS(SLOTS)) u_track (
      .clock      (clock),
      .reset      (reset),
      .ctl        (trk_ctl),
      .slot_idx   (samp_idx_ff),
      .entry      (mem_rdata),
      .now        (now_ff),
      .found      (best_found),
      .best_slot  (best_slot),
      .best_entry (best_entry)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_payload.func == FUNC_TICK) ? ST_SCAN : ST_ADD;
            end
         end
         ST_ADD: begin
            // Leave once a free slot is taken or the walk hit the end full
            if (out_free && (slot_free || is_last)) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (is_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      idx_in        = idx_ff;
      samp_in       = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = best_entry;
      mem_re        = 1'b0;
      trk_ctl.clear = 1'b0;
      trk_ctl.sample     = samp_ff;
      trk_ctl.slot_valid = valid_ff[samp_idx_ff];
      valid_set     = 1'b0;
      valid_clr     = 1'b0;
      valid_idx     = idx_ff;
      now_in        = now_ff;
      rsp_load      = 1'b0;
      rsp_in        = '0;
      case (state_ff)
         ST_IDLE: begin
            // Restart the walk and drop the previous candidate
            idx_in        = '0;
            trk_ctl.clear = req_accept;
         end
         ST_ADD: begin
            if (slot_free) begin
               if (out_free) begin
                  mem_we              = 1'b1;
                  mem_wdata.proc_id   = req_ff.proc_id;
                  mem_wdata.arrival   = req_ff.arrival;
                  mem_wdata.burst     = req_ff.burst;
                  mem_wdata.prio      = req_ff.priority_req;
                  mem_wdata.remaining = req_ff.burst;
                  valid_set     = 1'b1;
                  rsp_load      = 1'b1;
                  rsp_in.status = STATUS_ADDED;
               end
            end else if (is_last) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_in.status = STATUS_FULL;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_SCAN: begin
            // Issue one read a cycle; data lands in the tracker next cycle
            mem_re  = 1'b1;
            samp_in = 1'b1;
            idx_in  = idx_ff + IDX_W'(1);
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_load = 1'b1;
               now_in   = comp;
               if (best_found) begin
                  mem_we    = 1'b1;
                  mem_waddr = best_slot;
                  valid_idx = best_slot;
                  rsp_in.status = STATUS_RAN;
                  rsp_in.run_id = best_entry.proc_id;
                  if (done) begin
                     mem_wdata.remaining = '0;
                     valid_clr         = 1'b1;
                     rsp_in.finished   = 1'b1;
                     rsp_in.completion = comp;
                     rsp_in.turnaround = tat;
                     rsp_in.wait_time  = wt;
                  end else begin
                     mem_wdata.remaining = best_entry.remaining - 16'd1;
                  end
               end else begin
                  rsp_in.status = STATUS_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         samp_ff      <= 1'b0;
         valid_ff     <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         samp_ff      <= samp_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
         if (valid_set) begin
            valid_ff[valid_idx] <= 1'b1;
         end else if (valid_clr) begin
            valid_ff[valid_idx] <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      samp_idx_ff <= idx_ff;
      if (req_accept) begin
         req_ff <= req_payload;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
